[design/ple_pkg.sv]
// Package for the positional list engine: operation codes, status codes,
// field widths and the per-cell shift control. No dependencies.
`timescale 1ns / 1ps

package ple_pkg;

  localparam int MODE_W  = 3;
  localparam int ELEM_W  = 16;
  localparam int POS_W   = 6;
  localparam int STAT_W  = 2;
  localparam int LEN_W   = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_INS_HEAD = 3'd0,
    MODE_INS_TAIL = 3'd1,
    MODE_INS_AT   = 3'd2,
    MODE_REM_HEAD = 3'd3,
    MODE_REM_TAIL = 3'd4,
    MODE_REM_AT   = 3'd5,
    MODE_READ_AT  = 3'd6
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // Broadcast to every cell: open a gap or close one at the chosen index.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

[design/ple_if.sv]
// Valid/ready channel interfaces for the positional list engine.
// Depends on ple_pkg for the field widths.
`timescale 1ns / 1ps

interface ple_in_if;
  logic                        valid;
  logic                        ready;
  logic [ple_pkg::MODE_W-1:0]  mode;
  logic [ple_pkg::ELEM_W-1:0]  element;
  logic [ple_pkg::POS_W-1:0]   position;

  modport source (output valid, mode, element, position, input ready);
  modport sink   (input valid, mode, element, position, output ready);
endinterface

interface ple_out_if;
  logic                        valid;
  logic                        ready;
  logic [ple_pkg::ELEM_W-1:0]  value_out;
  logic [ple_pkg::STAT_W-1:0]  status;
  logic [ple_pkg::LEN_W-1:0]   length;

  modport source (output valid, value_out, status, length, input ready);
  modport sink   (input valid, value_out, status, length, output ready);
endinterface

[design/ple_cell.sv]
// One list slot of the positional list engine. It takes its left or right
// neighbor's value or the new element as the broadcast control says.
// Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_cell #(
  parameter int IDX = 0,
  parameter int AW  = 7
) (
  input  logic                       clk_i,
  input  ple_pkg::cell_ctl_t         ctl_i,
  input  logic [AW-1:0]              at_i,
  input  logic [ple_pkg::ELEM_W-1:0] elem_i,
  input  logic [ple_pkg::ELEM_W-1:0] left_i,
  input  logic [ple_pkg::ELEM_W-1:0] right_i,
  output logic [ple_pkg::ELEM_W-1:0] data_o,
  output logic [ple_pkg::ELEM_W-1:0] sel_o
);

  localparam logic [AW-1:0] MyIdx = AW'(IDX);

  logic [ple_pkg::ELEM_W-1:0] data_q, data_d;
  logic                       eq, above;

  assign eq    = (at_i == MyIdx);
  assign above = (MyIdx > at_i);

  always_comb begin
    data_d = data_q;
    if (ctl_i.ins) begin
      if (eq) begin
        data_d = elem_i;
      end else if (above) begin
        data_d = left_i;
      end
    end else if (ctl_i.rem && (eq || above)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // Only the addressed cell drives the read bus; the others give zero.
  assign sel_o  = eq ? data_q : '0;

endmodule

[design/positional_list_engine.sv]
// Top level of the positional list engine: control, length counter and
// the chain of slot cells. Depends on ple_pkg, ple_if and ple_cell.
//
// Usage: items enter on in_i (mode, element, position) and one result per
// item leaves on out_o (value_out, status, length). A beat is taken on
// in_i whenever the output register is empty or is being drained in the
// same cycle, so one item is accepted per cycle while out_o keeps up.
// The result of an item is on out_o in the cycle after its beat. Every
// insert or remove is done at that beat by all cells shifting in parallel
// toward or away from the addressed slot; the removed or read slot is
// picked off an OR bus across the cells. Errors (bad position, full list,
// empty list) leave the list unchanged and return a zero value. Reset
// clears the length and the output valid; slot contents are not cleared,
// as only slots below the length are read. When out_o stalls, the result
// holds and in_i drops ready until the result beat is taken.
`timescale 1ns / 1ps

module positional_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ple_in_if.sink    in_i,
  ple_out_if.source out_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;
  localparam logic [AW-1:0] CapA = AW'(CAPACITY);

  logic [CW-1:0]              count_q, count_d;
  logic                       out_valid_q;
  logic [ple_pkg::ELEM_W-1:0] value_q, value_d;
  ple_pkg::status_e           status_q, status_d;
  logic [ple_pkg::LEN_W-1:0]  length_q;

  logic                       fire;
  logic [AW-1:0]              cnt_a, pos_a, at;
  logic                       ins_ok, rem_ok, rd_ok;
  ple_pkg::cell_ctl_t         ctl;
  ple_pkg::mode_e             mode;

  logic [ple_pkg::ELEM_W-1:0] data [CAPACITY];
  logic [ple_pkg::ELEM_W-1:0] sel  [CAPACITY];
  logic [ple_pkg::ELEM_W-1:0] rd_data;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign fire       = in_i.valid && in_i.ready;
  assign mode       = ple_pkg::mode_e'(in_i.mode);
  assign cnt_a      = AW'(count_q);
  assign pos_a      = AW'(in_i.position);

  always_comb begin
    at       = '0;
    ins_ok   = 1'b0;
    rem_ok   = 1'b0;
    rd_ok    = 1'b0;
    status_d = ple_pkg::ST_OK;
    case (mode)
      ple_pkg::MODE_INS_HEAD, ple_pkg::MODE_INS_TAIL, ple_pkg::MODE_INS_AT: begin
        if (mode == ple_pkg::MODE_INS_TAIL) begin
          at = cnt_a;
        end else if (mode == ple_pkg::MODE_INS_AT) begin
          at = pos_a;
        end
        if (at > cnt_a) begin
          status_d = ple_pkg::ST_BADPOS;
        end else if (cnt_a >= CapA) begin
          status_d = ple_pkg::ST_FULL;
        end else begin
          ins_ok = 1'b1;
        end
      end
      ple_pkg::MODE_REM_HEAD, ple_pkg::MODE_REM_TAIL, ple_pkg::MODE_REM_AT,
      ple_pkg::MODE_READ_AT: begin
        if (mode == ple_pkg::MODE_REM_TAIL) begin
          at = cnt_a - AW'(1);
        end else if (mode != ple_pkg::MODE_REM_HEAD) begin
          at = pos_a;
        end
        if (cnt_a == '0) begin
          status_d = ple_pkg::ST_EMPTY;
        end else if (at >= cnt_a) begin
          status_d = ple_pkg::ST_BADPOS;
        end else if (mode == ple_pkg::MODE_READ_AT) begin
          rd_ok = 1'b1;
        end else begin
          rem_ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign ctl.ins = fire && ins_ok;
  assign ctl.rem = fire && rem_ok;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ple_pkg::ELEM_W-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = in_i.element;
    end else begin : g_mid
      assign left = data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_body
      assign right = data[g+1];
    end
    ple_cell #(
      .IDX (g),
      .AW  (AW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .at_i    (at),
      .elem_i  (in_i.element),
      .left_i  (left),
      .right_i (right),
      .data_o  (data[g]),
      .sel_o   (sel[g])
    );
  end

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | sel[i];
    end
  end

  assign value_d = (rem_ok || rd_ok) ? rd_data : '0;

  always_comb begin
    count_d = count_q;
    if (ctl.ins) begin
      count_d = count_q + CW'(1);
    end else if (ctl.rem) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      value_q  <= value_d;
      status_q <= status_d;
      length_q <= ple_pkg::LEN_W'(count_d);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.value_out = value_q;
  assign out_o.status    = status_q;
  assign out_o.length    = length_q;

endmodule

[design/ple_checker.sv]
// Port-level checks for the positional list engine, attached by bind.
// Depends on ple_pkg and the positional_list_engine top level.
`timescale 1ns / 1ps

module ple_checker #(
  parameter int CAPACITY = 64
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [ple_pkg::STAT_W-1:0] status_i,
  input logic [ple_pkg::LEN_W-1:0]  length_i
);

  // A stalled result beat keeps its status and length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) && $stable(length_i))
    else $error("stalled result changed");

  // Every accepted item shows its result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("no result after accepted item");

  // The input side only waits on a held result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a held result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ple_pkg::ST_FULL |-> length_i == ple_pkg::LEN_W'(CAPACITY))
    else $error("full status with a length below capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ple_pkg::ST_EMPTY |-> length_i == '0)
    else $error("empty status with a nonzero length");

endmodule

bind positional_list_engine ple_checker #(
  .CAPACITY (CAPACITY)
) u_ple_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.status),
  .length_i    (out_o.length)
);

[tb/positional_list_engine_tb.sv]
// Self-checking testbench for positional_list_engine: random and directed list operations
// checked beat by beat against an in-bench list predictor.
// Depends on ple_pkg, ple_if and the engine RTL.
`timescale 1ns / 1ps

module positional_list_engine_tb;

  localparam int LIST_CAP = 64;
  localparam int RANDOM_OPS = 1050;
  localparam logic [ple_pkg::MODE_W-1:0] MODE_NONE = 3'd7;

  typedef struct packed {
    logic [ple_pkg::MODE_W-1:0] mode;
    logic [ple_pkg::ELEM_W-1:0] element;
    logic [ple_pkg::POS_W-1:0]  position;
    logic                       hold;      // wait for every reply before this beat
  } list_op_t;

  typedef struct packed {
    logic [ple_pkg::ELEM_W-1:0] value;
    logic [ple_pkg::STAT_W-1:0] status;
    logic [ple_pkg::LEN_W-1:0]  length;
  } list_reply_t;

  typedef struct packed {
    logic [LIST_CAP-1:0][ple_pkg::ELEM_W-1:0] slots;
    logic [ple_pkg::LEN_W-1:0]                len;
  } list_image_t;

  logic clk_i;
  logic rst_ni;

  ple_in_if  in_bus ();
  ple_out_if out_bus ();

  positional_list_engine #(
    .CAPACITY(LIST_CAP)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  list_op_t    op_queue[$];
  list_reply_t pending_replies[$];
  list_image_t gen_img;
  list_image_t dut_img;
  list_op_t    cur_op;
  int          total_ops;
  int          items_sent;
  int          results_seen;
  int          errors;
  int          burst_left;
  int          gap_left;
  int          stall_mode;
  int          stretch_left;
  int          tick;
  int          mode_hits[8];
  int          status_hits[4];
  int          peak_len;

  // Applies one operation to a list image and returns the updated image.
  function automatic list_image_t list_apply(input list_image_t st, input list_op_t op,
                                             output list_reply_t rs);
    list_image_t nx;
    int          at;
    int          k;
    nx = st;
    rs.value = '0;
    rs.status = ple_pkg::ST_OK;
    case (op.mode)
      ple_pkg::MODE_INS_HEAD, ple_pkg::MODE_INS_TAIL, ple_pkg::MODE_INS_AT: begin
        if (op.mode == ple_pkg::MODE_INS_HEAD) at = 0;
        else if (op.mode == ple_pkg::MODE_INS_TAIL) at = int'(st.len);
        else at = int'(op.position);
        if (at > int'(st.len)) begin
          rs.status = ple_pkg::ST_BADPOS;
        end else if (int'(st.len) >= LIST_CAP) begin
          rs.status = ple_pkg::ST_FULL;
        end else begin
          for (k = int'(st.len); k > at; k--) nx.slots[k] = nx.slots[k-1];
          nx.slots[at] = op.element;
          nx.len = st.len + ple_pkg::LEN_W'(1);
        end
      end
      ple_pkg::MODE_REM_HEAD, ple_pkg::MODE_REM_TAIL, ple_pkg::MODE_REM_AT,
      ple_pkg::MODE_READ_AT: begin
        if (st.len == '0) begin
          rs.status = ple_pkg::ST_EMPTY;
        end else begin
          if (op.mode == ple_pkg::MODE_REM_HEAD) at = 0;
          else if (op.mode == ple_pkg::MODE_REM_TAIL) at = int'(st.len) - 1;
          else at = int'(op.position);
          if (at >= int'(st.len)) begin
            rs.status = ple_pkg::ST_BADPOS;
          end else begin
            rs.value = st.slots[at];
            if (op.mode != ple_pkg::MODE_READ_AT) begin
              for (k = at; k + 1 < int'(st.len); k++) nx.slots[k] = nx.slots[k+1];
              nx.len = st.len - ple_pkg::LEN_W'(1);
            end
          end
        end
      end
      default: ;
    endcase
    rs.length = nx.len;
    return nx;
  endfunction

  // The generator keeps its own image so that positions can be aimed at the live length.
  task automatic queue_op(input logic [ple_pkg::MODE_W-1:0] md,
                          input logic [ple_pkg::ELEM_W-1:0] el,
                          input logic [ple_pkg::POS_W-1:0] ps, input logic hd);
    list_op_t    op;
    list_reply_t unused;
    op.mode = md;
    op.element = el;
    op.position = ps;
    op.hold = hd;
    gen_img = list_apply(gen_img, op, unused);
    op_queue.push_back(op);
  endtask

  always #1 clk_i = ~clk_i;

  // Driver: bursts of beats separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    list_reply_t rs;
    logic        fire;
    logic        show;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      items_sent <= 0;
      burst_left = $urandom_range(1, 16);
      gap_left = 0;
    end else begin
      fire = in_bus.valid && in_bus.ready;
      if (fire) begin
        dut_img = list_apply(dut_img, cur_op, rs);
        pending_replies.push_back(rs);
        mode_hits[cur_op.mode]++;
        items_sent <= items_sent + 1;
      end
      if (!in_bus.valid || fire) begin
        show = 1'b1;
        if (gap_left > 0) begin
          gap_left--;
          show = 1'b0;
        end else if (op_queue.size() == 0) begin
          show = 1'b0;
        end else if (op_queue[0].hold && (fire || items_sent != results_seen)) begin
          show = 1'b0;
        end
        if (show) begin
          cur_op = op_queue.pop_front();
          in_bus.mode <= cur_op.mode;
          in_bus.element <= cur_op.element;
          in_bus.position <= cur_op.position;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
        in_bus.valid <= show;
      end
    end
  end

  // Monitor: checks each result beat and drives a changing stall pattern on ready.
  always @(posedge clk_i or negedge rst_ni) begin
    list_reply_t want;
    logic        rdy;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      results_seen <= 0;
      stall_mode = 0;
      stretch_left = 50;
      tick = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        results_seen <= results_seen + 1;
        if (pending_replies.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat: value %h status %0d length %0d", $time,
                   out_bus.value_out, out_bus.status, out_bus.length);
        end else begin
          want = pending_replies.pop_front();
          status_hits[want.status]++;
          if (int'(want.length) > peak_len) peak_len = int'(want.length);
          if (out_bus.value_out !== want.value) begin
            errors++;
            $display("%0t: value_out mismatch: expected %h, got %h", $time, want.value,
                     out_bus.value_out);
          end
          if (out_bus.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status,
                     out_bus.status);
          end
          if (out_bus.length !== want.length) begin
            errors++;
            $display("%0t: length mismatch: expected %0d, got %0d", $time, want.length,
                     out_bus.length);
          end
        end
      end
      tick++;
      stretch_left--;
      if (stretch_left <= 0) begin
        stall_mode = $urandom_range(0, 3);
        stretch_left = $urandom_range(20, 150);
      end
      case (stall_mode)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 3) != 0);
        2: rdy = ($urandom_range(0, 3) == 0);
        default: rdy = (tick % 3 != 0);
      endcase
      out_bus.ready <= rdy;
    end
  end

  initial begin
    int                         phase_kind;
    int                         phase_len;
    int                         ins_pct;
    int                         r;
    int                         sub;
    int                         n_rand;
    int                         top;
    logic                       first;
    logic                       hd;
    logic [ple_pkg::MODE_W-1:0] md;
    logic [ple_pkg::POS_W-1:0]  ps;

    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.mode = '0;
    in_bus.element = '0;
    in_bus.position = '0;
    out_bus.ready = 1'b0;
    errors = 0;
    peak_len = 0;
    foreach (mode_hits[i]) mode_hits[i] = 0;
    foreach (status_hits[i]) status_hits[i] = 0;
    gen_img = '0;
    dut_img = '0;

    // Directed: removes, reads, a bad insert and mode 7 on an empty list, then a short build
    // and teardown that touches head, tail, append by position and out-of-range positions.
    queue_op(ple_pkg::MODE_READ_AT, 16'h0000, 6'd0, 1'b0);
    queue_op(ple_pkg::MODE_REM_HEAD, 16'hFFFF, 6'd0, 1'b0);
    queue_op(ple_pkg::MODE_REM_TAIL, 16'h0000, 6'd0, 1'b0);
    queue_op(ple_pkg::MODE_REM_AT, 16'h0000, 6'd63, 1'b0);
    queue_op(ple_pkg::MODE_INS_AT, 16'h1111, 6'd5, 1'b0);
    queue_op(MODE_NONE, 16'hFFFF, 6'd63, 1'b0);
    queue_op(ple_pkg::MODE_INS_AT, 16'h0000, 6'd0, 1'b0);
    queue_op(ple_pkg::MODE_INS_TAIL, 16'hFFFF, 6'd0, 1'b0);
    queue_op(ple_pkg::MODE_INS_HEAD, 16'hA5A5, 6'd63, 1'b0);
    queue_op(ple_pkg::MODE_INS_AT, 16'h5A5A, 6'd3, 1'b0);
    queue_op(ple_pkg::MODE_INS_AT, 16'h1234, 6'd1, 1'b0);
    queue_op(ple_pkg::MODE_READ_AT, 16'h0000, 6'd4, 1'b0);
    queue_op(ple_pkg::MODE_READ_AT, 16'h0000, 6'd5, 1'b0);
    queue_op(ple_pkg::MODE_READ_AT, 16'h0000, 6'd63, 1'b0);
    queue_op(ple_pkg::MODE_REM_AT, 16'h0000, 6'd63, 1'b0);
    queue_op(ple_pkg::MODE_REM_AT, 16'h0000, 6'd2, 1'b0);
    queue_op(MODE_NONE, 16'h0000, 6'd0, 1'b0);
    queue_op(ple_pkg::MODE_REM_HEAD, 16'h0000, 6'd0, 1'b0);
    queue_op(ple_pkg::MODE_REM_TAIL, 16'h0000, 6'd0, 1'b0);
    queue_op(ple_pkg::MODE_REM_AT, 16'h0000, 6'd0, 1'b0);
    queue_op(ple_pkg::MODE_REM_AT, 16'h0000, 6'd0, 1'b0);
    queue_op(ple_pkg::MODE_REM_TAIL, 16'h0000, 6'd0, 1'b0);

    // Random: phases that grow, shrink, mix or scramble the list. The first phase
    // is mostly inserts so the list nears capacity and full-list rejects can be hit early.
    n_rand = 0;
    first = 1'b1;
    while (n_rand < RANDOM_OPS) begin
      phase_kind = first ? 0 : $urandom_range(0, 3);
      phase_len = first ? 120 : $urandom_range(30, 100);
      case (phase_kind)
        0: ins_pct = 80;
        1: ins_pct = 20;
        2: ins_pct = 50;
        default: ins_pct = 45;
      endcase
      for (int i = 0; i < phase_len && n_rand < RANDOM_OPS; i++) begin
        hd = (i == 0) && (first || $urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (phase_kind == 3 && r < 40) begin
          md = ple_pkg::MODE_W'($urandom_range(0, 7));
          ps = ple_pkg::POS_W'($urandom_range(0, 63));
        end else if (r >= 96) begin
          md = MODE_NONE;
          ps = ple_pkg::POS_W'($urandom_range(0, 63));
        end else if (r < ins_pct) begin
          sub = $urandom_range(0, 2);
          md = (sub == 0) ? ple_pkg::MODE_INS_HEAD :
               (sub == 1) ? ple_pkg::MODE_INS_TAIL : ple_pkg::MODE_INS_AT;
          top = (int'(gen_img.len) > 63) ? 63 : int'(gen_img.len);
          ps = ($urandom_range(0, 9) == 0) ? ple_pkg::POS_W'($urandom_range(0, 63)) :
                                             ple_pkg::POS_W'($urandom_range(0, top));
        end else begin
          sub = $urandom_range(0, 3);
          case (sub)
            0: md = ple_pkg::MODE_REM_HEAD;
            1: md = ple_pkg::MODE_REM_TAIL;
            2: md = ple_pkg::MODE_REM_AT;
            default: md = ple_pkg::MODE_READ_AT;
          endcase
          if (gen_img.len == '0 || $urandom_range(0, 9) == 0) begin
            ps = ple_pkg::POS_W'($urandom_range(0, 63));
          end else begin
            ps = ple_pkg::POS_W'($urandom_range(0, int'(gen_img.len) - 1));
          end
        end
        queue_op(md, ple_pkg::ELEM_W'($urandom_range(0, 65535)), ps, hd);
        if (md != MODE_NONE) n_rand++;
      end
      first = 1'b0;
    end
    total_ops = op_queue.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (results_seen != total_ops) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pending_replies.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, pending_replies.size());
    end

    $display("Covered %0d operations: %0d ok, %0d bad position, %0d full, %0d empty;",
             total_ops, status_hits[ple_pkg::ST_OK], status_hits[ple_pkg::ST_BADPOS],
             status_hits[ple_pkg::ST_FULL], status_hits[ple_pkg::ST_EMPTY]);
    $display("Peak length %0d; per mode: %0d %0d %0d %0d %0d %0d %0d %0d (modes 0 to 7).",
             peak_len, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
             mode_hits[4], mode_hits[5], mode_hits[6], mode_hits[7]);
    if (errors == 0) begin
      $display("positional_list_engine verification clean");
    end else begin
      $display("positional_list_engine verification failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("positional_list_engine verification failed");
    $finish;
  end

endmodule
